### rtl/aicc_pkg.sv
// ----------------------------------------------------------------------------
// aicc_pkg
// shared types, field widths, register indexes and status codes of the
// internal channel conversion block
// ----------------------------------------------------------------------------
package aicc_pkg;

    localparam int ADC_BITS_DEF = 12;

    // field widths
    localparam int CODE_W     = 12;
    localparam int CAL_W      = 12;
    localparam int VREF_W     = 11;
    localparam int SUPPLY_W   = 23;
    localparam int TEMP_W     = 7;
    localparam int VBAT_W     = 24;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // conversion constants
    localparam int CAL_REF_MV = 3300;
    localparam int CAL_REF_W  = 12;
    localparam int T_LOW      = 30;
    localparam int T_SPAN     = 80;
    localparam int T_SPAN_W   = 7;
    localparam int VREF_RESET = 1210;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VREF_TYP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CAL_BAD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SUPPLY = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] temp_code;
        logic [CODE_W-1:0] vref_code;
        logic [CODE_W-1:0] vbat_code;
    } t_in;

    typedef struct packed {
        logic [SUPPLY_W-1:0] supply_mv;
        logic [TEMP_W-1:0]   temp_c;
        logic [VBAT_W-1:0]   vbat_mv;
        logic [STATUS_W-1:0] status;
    } t_out;

endpackage

### rtl/aicc_div.sv
// ----------------------------------------------------------------------------
// aicc_div
// pipelined restoring divider, one quotient bit per register stage, with a
// valid bit and a sideband word traveling alongside each transaction
// ----------------------------------------------------------------------------
module aicc_div #(
    parameter int N_W  = 8,
    parameter int D_W  = 8,
    parameter int SB_W = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [N_W-1:0]  i_num,
    input  logic [D_W-1:0]  i_den,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_vld,
    output logic [N_W-1:0]  o_quo,
    output logic [SB_W-1:0] o_sb
);

    logic            r_vld [N_W];
    logic [N_W-1:0]  r_num [N_W];
    logic [SB_W-1:0] r_sb  [N_W];
    logic [D_W-1:0]  r_rem [N_W-1];
    logic [D_W-1:0]  r_den [N_W-1];

    logic [N_W-1:0]  c_num   [N_W];
    logic [D_W-1:0]  c_rem   [N_W];
    logic [D_W-1:0]  c_den   [N_W];
    logic [D_W:0]    c_trial [N_W];
    logic [D_W:0]    c_diff  [N_W];
    logic            c_ge    [N_W];
    logic [N_W-1:0]  n_num   [N_W];
    logic [D_W-1:0]  n_rem   [N_W];

    always_comb begin
        for (int s = 0; s < N_W; s++) begin
            if (s == 0) begin
                c_num[s] = i_num;
                c_rem[s] = '0;
                c_den[s] = i_den;
            end else begin
                c_num[s] = r_num[s-1];
                c_rem[s] = r_rem[s-1];
                c_den[s] = r_den[s-1];
            end
            c_trial[s] = {c_rem[s], c_num[s][N_W-1]};
            c_diff[s]  = c_trial[s] - {1'b0, c_den[s]};
            c_ge[s]    = (c_trial[s] >= {1'b0, c_den[s]});
            n_num[s]   = {c_num[s][N_W-2:0], c_ge[s]};
            n_rem[s]   = c_ge[s] ? c_diff[s][D_W-1:0] : c_trial[s][D_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N_W; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < N_W; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= i_sb;
        for (int s = 1; s < N_W; s++) begin
            r_sb[s] <= r_sb[s-1];
        end
        for (int s = 0; s < N_W; s++) begin
            r_num[s] <= n_num[s];
        end
        for (int s = 0; s < N_W - 1; s++) begin
            r_rem[s] <= n_rem[s];
            r_den[s] <= c_den[s];
        end
    end

    assign o_vld = r_vld[N_W-1];
    assign o_quo = r_num[N_W-1];
    assign o_sb  = r_sb[N_W-1];

endmodule

### rtl/adc_internal_channel_conversion_top.sv
// ----------------------------------------------------------------------------
// adc_internal_channel_conversion_top
// converts one set of raw internal channel codes into supply and battery
// millivolts and a two-point calibrated chip temperature
// ----------------------------------------------------------------------------
// One code set is taken every clock cycle; busy is high only while reset is
// applied. Each transaction yields one result, shown on o_out for a single
// cycle with o_done high. The pipeline holds three bit-per-stage dividers in
// a chain: supply, rescaled sensor code and temperature interpolation; the
// battery division by the all-ones code takes two stages of folded shifts.
// The results cannot be held off, so they must be taken as they appear.
// Configuration is read live by the pipeline; the user must write it only
// while no transaction is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module adc_internal_channel_conversion_top #(
    parameter int ADC_BITS = aicc_pkg::ADC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  aicc_pkg::t_in                    i_in,
    output logic                             o_done,
    output aicc_pkg::t_out                   o_out,
    input  logic                             i_cfg_we,
    input  logic [aicc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [aicc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int AB       = ADC_BITS;
    localparam int EXT_W    = (AB > aicc_pkg::CODE_W) ? AB : aicc_pkg::CODE_W;
    localparam int SUP_W    = aicc_pkg::VREF_W + AB;
    localparam int PV_W     = SUP_W + AB;
    localparam int PS_W     = PV_W + 1;
    localparam int Q_W      = PS_W - AB;
    localparam int PV_TERMS = (PV_W + AB - 1) / AB;
    localparam int PT_W     = AB + aicc_pkg::CAL_REF_W;
    localparam int INT_W    = aicc_pkg::CAL_W + aicc_pkg::T_SPAN_W;
    localparam int LAT      = 6 + SUP_W + PT_W + INT_W;
    localparam int CAL_W    = aicc_pkg::CAL_W;
    localparam int TEMP_W   = aicc_pkg::TEMP_W;

    localparam logic [AB-1:0] ADC_MAX = '1;

    localparam logic [1:0] TSEL_ZERO   = 2'd0;
    localparam logic [1:0] TSEL_LOW    = 2'd1;
    localparam logic [1:0] TSEL_HIGH   = 2'd2;
    localparam logic [1:0] TSEL_INTERP = 2'd3;

    typedef struct packed {
        logic [AB-1:0] tc;
        logic [AB-1:0] vb;
        logic          vref_zero;
    } t_sb1;

    typedef struct packed {
        logic [SUP_W-1:0]               sup;
        logic [aicc_pkg::VBAT_W-1:0]    vbat;
    } t_sb3;

    typedef struct packed {
        logic [aicc_pkg::SUPPLY_W-1:0]  sup;
        logic [aicc_pkg::VBAT_W-1:0]    vbat;
        logic [aicc_pkg::STATUS_W-1:0]  status;
        logic [1:0]                     tsel;
    } t_sb4;

    // configuration registers
    logic [CAL_W-1:0]             r_cal_low;
    logic [CAL_W-1:0]             r_cal_high;
    logic [aicc_pkg::VREF_W-1:0]  r_vref_typ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_low  <= '0;
            r_cal_high <= '0;
            r_vref_typ <= aicc_pkg::VREF_W'(aicc_pkg::VREF_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aicc_pkg::REG_CAL_LOW:  r_cal_low  <= i_cfg_wdata[CAL_W-1:0];
                aicc_pkg::REG_CAL_HIGH: r_cal_high <= i_cfg_wdata[CAL_W-1:0];
                aicc_pkg::REG_VREF_TYP: r_vref_typ <= i_cfg_wdata[aicc_pkg::VREF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign busy = ~i_rst_n;

    logic w_accept;
    assign w_accept = start & ~busy;

    // input stage
    logic [EXT_W-1:0] w_tc_ext;
    logic [EXT_W-1:0] w_vr_ext;
    logic [EXT_W-1:0] w_vb_ext;
    assign w_tc_ext = EXT_W'(i_in.temp_code);
    assign w_vr_ext = EXT_W'(i_in.vref_code);
    assign w_vb_ext = EXT_W'(i_in.vbat_code);

    logic             r_a_vld;
    logic [SUP_W-1:0] r_a_num;
    logic [AB-1:0]    r_a_den;
    logic [AB-1:0]    r_a_tc;
    logic [AB-1:0]    r_a_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_num <= SUP_W'(r_vref_typ) * SUP_W'(ADC_MAX);
        r_a_den <= w_vr_ext[AB-1:0];
        r_a_tc  <= w_tc_ext[AB-1:0];
        r_a_vb  <= w_vb_ext[AB-1:0];
    end

    // supply divider
    t_sb1             w_sb1_in;
    t_sb1             w_sb1_out;
    logic             w_d1_vld;
    logic [SUP_W-1:0] w_d1_quo;

    assign w_sb1_in.tc        = r_a_tc;
    assign w_sb1_in.vb        = r_a_vb;
    assign w_sb1_in.vref_zero = (r_a_den == '0);

    aicc_div #(
        .N_W  (SUP_W),
        .D_W  (AB),
        .SB_W ($bits(t_sb1))
    ) u_div_supply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_a_vld),
        .i_num   (r_a_num),
        .i_den   (r_a_den),
        .i_sb    (w_sb1_in),
        .o_vld   (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_sb    (w_sb1_out)
    );

    // product stage
    logic [SUP_W-1:0] w_supply;
    assign w_supply = w_sb1_out.vref_zero ? '0 : w_d1_quo;

    logic             r_b_vld;
    logic [SUP_W-1:0] r_b_sup;
    logic [PV_W-1:0]  r_b_pv;
    logic [PT_W-1:0]  r_b_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= w_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_sup <= w_supply;
        r_b_pv  <= PV_W'(w_supply) * PV_W'(w_sb1_out.vb);
        r_b_pt  <= PT_W'(w_sb1_out.tc) * PT_W'(aicc_pkg::CAL_REF_MV);
    end

    // battery division by the all-ones code: folded shift sum gives the
    // quotient or one less, the remainder decides the final increment
    logic [PS_W-1:0] w_v_sum;

    always_comb begin
        w_v_sum = '0;
        for (int k = 0; k < PV_TERMS; k++) begin
            w_v_sum = w_v_sum + PS_W'(r_b_pv >> (k * AB));
        end
    end

    logic             r_v1_vld;
    logic [Q_W-1:0]   r_v1_q;
    logic [AB:0]      r_v1_lo;
    logic [SUP_W-1:0] r_v1_sup;
    logic [PT_W-1:0]  r_v1_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_vld <= 1'b0;
        end else begin
            r_v1_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1_q   <= w_v_sum[PS_W-1:AB];
        r_v1_lo  <= r_b_pv[AB:0];
        r_v1_sup <= r_b_sup;
        r_v1_pt  <= r_b_pt;
    end

    logic [AB:0] w_v_qm;
    logic [AB:0] w_v_rem;
    assign w_v_qm  = {r_v1_q[0], {AB{1'b0}}} - r_v1_q[AB:0];
    assign w_v_rem = r_v1_lo - w_v_qm;

    logic             r_v2_vld;
    logic [Q_W-1:0]   r_v2_q;
    logic             r_v2_fix;
    logic [SUP_W-1:0] r_v2_sup;
    logic [PT_W-1:0]  r_v2_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2_vld <= 1'b0;
        end else begin
            r_v2_vld <= r_v1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v2_q   <= r_v1_q;
        r_v2_fix <= (w_v_rem >= {1'b0, ADC_MAX});
        r_v2_sup <= r_v1_sup;
        r_v2_pt  <= r_v1_pt;
    end

    logic [Q_W-1:0] w_vbat_quo;
    assign w_vbat_quo = r_v2_q + Q_W'(r_v2_fix);

    // sensor rescale divider
    t_sb3            w_sb3_in;
    t_sb3            w_sb3_out;
    logic            w_d3_vld;
    logic [PT_W-1:0] w_scaled;

    assign w_sb3_in.sup  = r_v2_sup;
    assign w_sb3_in.vbat = aicc_pkg::VBAT_W'({w_vbat_quo, 1'b0});

    aicc_div #(
        .N_W  (PT_W),
        .D_W  (SUP_W),
        .SB_W ($bits(t_sb3))
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v2_vld),
        .i_num   (r_v2_pt),
        .i_den   (r_v2_sup),
        .i_sb    (w_sb3_in),
        .o_vld   (w_d3_vld),
        .o_quo   (w_scaled),
        .o_sb    (w_sb3_out)
    );

    // classify and set up interpolation
    logic                          w_cal_bad;
    logic                          w_sup_zero;
    logic                          w_le_low;
    logic                          w_ge_high;
    logic [CAL_W-1:0]              w_diff;
    logic [aicc_pkg::STATUS_W-1:0] n_c_status;
    logic [1:0]                    n_c_tsel;

    assign w_cal_bad  = (r_cal_low == '0) || (r_cal_high <= r_cal_low);
    assign w_sup_zero = (w_sb3_out.sup == '0);
    assign w_le_low   = (w_scaled <= PT_W'(r_cal_low));
    assign w_ge_high  = (w_scaled >= PT_W'(r_cal_high));
    assign w_diff     = w_scaled[CAL_W-1:0] - r_cal_low;

    always_comb begin
        if (w_cal_bad) begin
            n_c_status = aicc_pkg::ST_CAL_BAD;
            n_c_tsel   = TSEL_ZERO;
        end else if (w_sup_zero) begin
            n_c_status = aicc_pkg::ST_NO_SUPPLY;
            n_c_tsel   = TSEL_ZERO;
        end else if (w_le_low) begin
            n_c_status = aicc_pkg::ST_OK;
            n_c_tsel   = TSEL_LOW;
        end else if (w_ge_high) begin
            n_c_status = aicc_pkg::ST_OK;
            n_c_tsel   = TSEL_HIGH;
        end else begin
            n_c_status = aicc_pkg::ST_OK;
            n_c_tsel   = TSEL_INTERP;
        end
    end

    logic             r_c_vld;
    logic [INT_W-1:0] r_c_num;
    logic [CAL_W-1:0] r_c_den;
    t_sb4             r_c_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= w_d3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_num        <= (n_c_tsel == TSEL_INTERP) ?
                          INT_W'(w_diff) * INT_W'(aicc_pkg::T_SPAN) : '0;
        r_c_den        <= r_cal_high - r_cal_low;
        r_c_sb.sup     <= aicc_pkg::SUPPLY_W'(w_sb3_out.sup);
        r_c_sb.vbat    <= w_sb3_out.vbat;
        r_c_sb.status  <= n_c_status;
        r_c_sb.tsel    <= n_c_tsel;
    end

    // interpolation divider
    t_sb4             w_sb4_out;
    logic             w_d4_vld;
    logic [INT_W-1:0] w_d4_quo;

    aicc_div #(
        .N_W  (INT_W),
        .D_W  (CAL_W),
        .SB_W ($bits(t_sb4))
    ) u_div_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_c_vld),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .i_sb    (r_c_sb),
        .o_vld   (w_d4_vld),
        .o_quo   (w_d4_quo),
        .o_sb    (w_sb4_out)
    );

    // output register
    logic [TEMP_W-1:0] n_temp;

    always_comb begin
        case (w_sb4_out.tsel)
            TSEL_ZERO:   n_temp = '0;
            TSEL_LOW:    n_temp = TEMP_W'(aicc_pkg::T_LOW);
            TSEL_HIGH:   n_temp = TEMP_W'(aicc_pkg::T_LOW + aicc_pkg::T_SPAN);
            TSEL_INTERP: n_temp = TEMP_W'(aicc_pkg::T_LOW) + w_d4_quo[TEMP_W-1:0];
            default:     n_temp = '0;
        endcase
    end

    logic           r_done;
    aicc_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_d4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.supply_mv <= w_sb4_out.sup;
        r_out.temp_c    <= n_temp;
        r_out.vbat_mv   <= w_sb4_out.vbat;
        r_out.status    <= w_sb4_out.status;
    end

    assign o_done = r_done;
    assign o_out  = r_out;

    // each transaction comes out after exactly the pipeline latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_done)
        else $error("result missing after pipeline latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, LAT))
        else $error("result without matching transaction");

    a_temp_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.status == aicc_pkg::ST_OK) |->
        (o_out.temp_c >= TEMP_W'(aicc_pkg::T_LOW) &&
         o_out.temp_c <= TEMP_W'(aicc_pkg::T_LOW + aicc_pkg::T_SPAN)))
        else $error("temperature outside calibrated span");

    a_temp_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.status != aicc_pkg::ST_OK) |-> (o_out.temp_c == '0))
        else $error("temperature not cleared on error status");

endmodule
